@@ hdl/vmea_pkg.sv @@
package vmea_pkg;

	localparam int UNITS_W = 16;
	localparam int SPD_W = 10;
	localparam int PER_W = 10;
	localparam int ID_W = 32;
	localparam int FUNC_W = 3;
	localparam int BTN_W = 3;
	localparam int AXIS_W = 2;
	localparam int KIND_W = 2;
	localparam int PIX_W = 16;
	localparam int CFG_IDX_W = 3;

	// Scaling datapath widths: (sum - neutral) is 17 bits, times speed is 28,
	// times period is 38 signed; 25 * (max - min) is 22 bits signed.
	localparam int NUM_W = 17;
	localparam int P1_W = 28;
	localparam int P2_W = 38;
	localparam int MAG_W = 37;
	localparam int DEN_W = 22;
	localparam int DMAG_W = 21;

	localparam logic [FUNC_W-1:0] FN_PRESS = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MOVE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_OVERRIDE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_TICK = 3'd4;

	localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
	localparam logic [KIND_W-1:0] EV_UP = 2'd1;
	localparam logic [KIND_W-1:0] EV_MOVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_UNITS_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNITS_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNITS_NEUTRAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD = 3'd4;

	localparam int VWHEEL_AXIS = 3;

	typedef struct packed {
		logic load;
		logic mark;
		logic srch_start;
		logic srch_run;
		logic commit;
		logic tick_init;
		logic btn_step;
		logic scan_start;
		logic scan_run;
		logic ax_load;
		logic mul1;
		logic mul2;
		logic div_start;
		logic ax_result;
		logic ax_next;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic mark;
		logic move_ok;
		logic ovr;
		logic tick;
		logic srch_done;
		logic btn_done;
		logic tick_move;
		logic scan_done;
		logic ax_skip;
		logic div_done;
		logic ax_last;
	} sts_t;

endpackage

@@ hdl/vmea_div.sv @@
module vmea_div import vmea_pkg::*; #(
	parameter int NW = MAG_W,
	parameter int DW = DMAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      sh;
	logic             ge;

	// One quotient bit per cycle, restoring form on magnitudes.
	assign sh = {rem_q, quo_q[NW-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(sh - {1'b0, den_q}) : sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ hdl/vmea_dp.sv @@
module vmea_dp import vmea_pkg::*; #(
	parameter int SOURCE_SLOTS = 16,
	parameter int BUTTON_COUNT = 5,
	parameter int AXIS_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	input  logic [FUNC_W-1:0]           func,
	input  logic [BTN_W-1:0]            button,
	input  logic [AXIS_W-1:0]           axis,
	input  logic signed [UNITS_W-1:0]   movement_units,
	input  logic [ID_W-1:0]             source_id,
	input  logic                        override_present,
	input  logic [SPD_W-1:0]            speed_percent,
	input  logic                        has_focus,
	input  logic                        terminate,
	input  logic                        cfg_wr,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [UNITS_W-1:0]          cfg_data,
	output logic                        result_strobe,
	output logic [KIND_W-1:0]           event_kind,
	output logic [BTN_W-1:0]            event_button,
	output logic [AXIS_W-1:0]           event_axis,
	output logic signed [PIX_W-1:0]     pixels,
	output logic                        last
);

	localparam int SW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
	localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int CN = SOURCE_SLOTS * AXIS_COUNT;
	localparam int CW = (CN > 1) ? $clog2(CN) : 1;
	localparam int ACC_W = UNITS_W + $clog2(SOURCE_SLOTS);

	// Configuration registers.
	logic signed [UNITS_W-1:0] min_q, max_q, neu_q;
	logic [SPD_W-1:0]          dspd_q;
	logic [PER_W-1:0]          per_q;

	// Latched item.
	logic [FUNC_W-1:0]         func_q;
	logic [BTN_W-1:0]          button_q;
	logic [AXIS_W-1:0]         axis_q;
	logic signed [UNITS_W-1:0] units_q;
	logic [ID_W-1:0]           id_q;
	logic                      ovp_q;
	logic [SPD_W-1:0]          spd_in_q;
	logic                      focus_q, term_q;

	// Button state.
	logic [BUTTON_COUNT-1:0]   press_q, nrel_q, prev_q, nxt_q, chg_q;
	logic [BW-1:0]             bcnt_q;

	// Source table.
	logic [SOURCE_SLOTS-1:0]   src_vld_q;
	logic [SOURCE_SLOTS-1:0]   ovr_vld_q;
	logic [CN-1:0]             conw_q;
	logic [ID_W-1:0]           ident_mem [SOURCE_SLOTS];
	logic signed [UNITS_W-1:0] con_mem [CN];
	logic [SPD_W-1:0]          ovr_mem [SOURCE_SLOTS];

	// Slot walk shared by the source search and the tick scan.
	logic [SW-1:0]             sc_q;
	logic [AXW-1:0]            ac_q;
	logic                      issue_q;
	logic                      vs_s1, last_s1;
	logic [SW-1:0]             idx_s1;
	logic [ID_W-1:0]           id_rd_s1;
	logic                      src_vld_s1;
	logic signed [UNITS_W-1:0] con_rd_s1;
	logic                      gate_s1, ovg_s1;
	logic [SPD_W-1:0]          ovr_rd_s1;
	logic [SW-1:0]             fre_q, slot_q;
	logic                      fre_fnd_q, fnd_q;
	logic                      hit, walk_last;
	logic [CW-1:0]             caddr;

	// Commit.
	logic [SW-1:0]             sel;
	logic                      sel_ok;
	logic [CW-1:0]             waddr;

	// Axis scaling.
	logic signed [ACC_W-1:0]   acc_q [AXIS_COUNT];
	logic [SPD_W-1:0]          spd_q;
	logic                      spd_fnd_q;
	logic [AXW-1:0]            ax_q;
	logic signed [ACC_W-1:0]   acc_add;
	logic signed [ACC_W-1:0]   mn_x, mx_x, neu_x;
	logic signed [UNITS_W-1:0] cl;
	logic signed [NUM_W-1:0]   num_c, dif;
	logic signed [DEN_W-1:0]   den_c;
	logic signed [NUM_W-1:0]   num_q;
	logic signed [DEN_W-1:0]   den_q;
	logic signed [P1_W-1:0]    p1_q;
	logic signed [P2_W-1:0]    p2_q;
	logic                      sign_q;
	logic [MAG_W-1:0]          nmag;
	logic [DMAG_W-1:0]         dmag;
	logic                      div_done;
	logic [MAG_W-1:0]          quo;
	logic                      neg;
	logic signed [PIX_W-1:0]   pix_c;

	// Event staging: one event is held back so that the final one carries last.
	logic                      push_v;
	logic [KIND_W-1:0]         push_kind;
	logic [BTN_W-1:0]          push_btn;
	logic [AXIS_W-1:0]         push_axis;
	logic signed [PIX_W-1:0]   push_pix;
	logic                      pend_v_q;
	logic [KIND_W-1:0]         pend_kind_q;
	logic [BTN_W-1:0]          pend_btn_q;
	logic [AXIS_W-1:0]         pend_axis_q;
	logic signed [PIX_W-1:0]   pend_pix_q;
	logic                      ev_stb_q, ev_last_q;
	logic [KIND_W-1:0]         ev_kind_q;
	logic [BTN_W-1:0]          ev_btn_q;
	logic [AXIS_W-1:0]         ev_axis_q;
	logic signed [PIX_W-1:0]   ev_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'sh8000;
			max_q <= 16'sh7FFF;
			neu_q <= '0;
			dspd_q <= SPD_W'(100);
			per_q <= PER_W'(10);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_UNITS_MIN: min_q <= cfg_data;
				CFG_UNITS_MAX: max_q <= cfg_data;
				CFG_UNITS_NEUTRAL: neu_q <= cfg_data;
				CFG_DEFAULT_SPEED: dspd_q <= cfg_data[SPD_W-1:0];
				CFG_POLL_PERIOD: per_q <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			button_q <= button;
			axis_q <= axis;
			units_q <= movement_units;
			id_q <= source_id;
			ovp_q <= override_present;
			spd_in_q <= speed_percent;
			focus_q <= has_focus;
			term_q <= terminate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= '0;
			nrel_q <= '1;
			prev_q <= '0;
			nxt_q <= '0;
			chg_q <= '0;
			bcnt_q <= '0;
		end else begin
			if (cmd.mark && int'(button_q) < BUTTON_COUNT) begin
				if (func_q == FN_PRESS)
					press_q <= press_q | (BUTTON_COUNT'(1) << button_q);
				else
					nrel_q <= nrel_q & ~(BUTTON_COUNT'(1) << button_q);
			end
			if (cmd.tick_init) begin
				logic [BUTTON_COUNT-1:0] n;
				n = (focus_q && !term_q) ? (press_q | (prev_q & nrel_q)) : '0;
				nxt_q <= n;
				chg_q <= n ^ prev_q;
				prev_q <= n;
				press_q <= '0;
				nrel_q <= '1;
				bcnt_q <= '0;
			end else if (cmd.btn_step) begin
				nxt_q <= nxt_q >> 1;
				chg_q <= chg_q >> 1;
				bcnt_q <= bcnt_q + 1'b1;
			end
		end
	end

	assign caddr = CW'(int'(sc_q) * AXIS_COUNT + int'(ac_q));
	assign walk_last = (sc_q == SW'(SOURCE_SLOTS - 1)) && (ac_q == AXW'(AXIS_COUNT - 1));
	assign hit = vs_s1 && src_vld_s1 && (id_rd_s1 == id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
			ac_q <= '0;
			issue_q <= 1'b0;
			vs_s1 <= 1'b0;
			last_s1 <= 1'b0;
			idx_s1 <= '0;
			fre_q <= '0;
			fre_fnd_q <= 1'b0;
			slot_q <= '0;
			fnd_q <= 1'b0;
		end else begin
			vs_s1 <= 1'b0;
			if (cmd.srch_start || cmd.scan_start) begin
				sc_q <= '0;
				ac_q <= '0;
				issue_q <= 1'b1;
				fre_fnd_q <= 1'b0;
				fnd_q <= 1'b0;
			end else if (cmd.srch_run && issue_q) begin
				vs_s1 <= 1'b1;
				idx_s1 <= sc_q;
				last_s1 <= sc_q == SW'(SOURCE_SLOTS - 1);
				if (!src_vld_q[sc_q] && !fre_fnd_q) begin
					fre_q <= sc_q;
					fre_fnd_q <= 1'b1;
				end
				if (sc_q == SW'(SOURCE_SLOTS - 1))
					issue_q <= 1'b0;
				else
					sc_q <= sc_q + 1'b1;
			end else if (cmd.scan_run && issue_q) begin
				vs_s1 <= 1'b1;
				last_s1 <= walk_last;
				if (walk_last) begin
					issue_q <= 1'b0;
				end else if (ac_q == AXW'(AXIS_COUNT - 1)) begin
					ac_q <= '0;
					sc_q <= sc_q + 1'b1;
				end else begin
					ac_q <= ac_q + 1'b1;
				end
			end
			if (cmd.srch_run && hit && !fnd_q) begin
				slot_q <= idx_s1;
				fnd_q <= 1'b1;
			end
		end
	end

	// Flag reads of the walk, registered alongside the memory reads.
	always_ff @(posedge clk) begin
		src_vld_s1 <= src_vld_q[sc_q];
		gate_s1 <= conw_q[caddr] && src_vld_q[sc_q];
		ovg_s1 <= (ac_q == '0) && ovr_vld_q[sc_q] && src_vld_q[sc_q];
	end

	assign sel = fnd_q ? slot_q : fre_q;
	assign sel_ok = fnd_q || fre_fnd_q;
	assign waddr = CW'(int'(sel) * AXIS_COUNT + int'(axis_q));

	always_ff @(posedge clk) begin
		id_rd_s1 <= ident_mem[sc_q];
		if (cmd.commit && sel_ok && !fnd_q)
			ident_mem[sel] <= id_q;
	end

	always_ff @(posedge clk) begin
		con_rd_s1 <= con_mem[caddr];
		if (cmd.commit && sel_ok && func_q == FN_MOVE)
			con_mem[waddr] <= units_q;
	end

	always_ff @(posedge clk) begin
		ovr_rd_s1 <= ovr_mem[sc_q];
		if (cmd.commit && sel_ok && func_q == FN_OVERRIDE)
			ovr_mem[sel] <= spd_in_q;
	end

	// A contribution reads as zero until its source has written that axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_vld_q <= '0;
			ovr_vld_q <= '0;
			conw_q <= '0;
		end else if (cmd.commit && sel_ok) begin
			if (!fnd_q) begin
				src_vld_q[sel] <= 1'b1;
				ovr_vld_q[sel] <= 1'b0;
				for (int a = 0; a < AXIS_COUNT; a++)
					conw_q[CW'(int'(sel) * AXIS_COUNT + a)] <= 1'b0;
			end
			if (func_q == FN_MOVE)
				conw_q[waddr] <= 1'b1;
			if (func_q == FN_OVERRIDE)
				ovr_vld_q[sel] <= ovp_q;
		end
	end

	assign acc_add = acc_q[0] + (gate_s1 ? ACC_W'(con_rd_s1) : ACC_W'(0));

	// The accumulators form a ring so that the head always holds the current axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXIS_COUNT; a++)
				acc_q[a] <= '0;
			spd_q <= '0;
			spd_fnd_q <= 1'b0;
			ax_q <= '0;
		end else begin
			if (cmd.scan_start) begin
				for (int a = 0; a < AXIS_COUNT; a++)
					acc_q[a] <= '0;
				spd_q <= dspd_q;
				spd_fnd_q <= 1'b0;
				ax_q <= '0;
			end else if (cmd.scan_run && vs_s1) begin
				for (int a = 0; a < AXIS_COUNT - 1; a++)
					acc_q[a] <= acc_q[a+1];
				acc_q[AXIS_COUNT-1] <= acc_add;
				if (ovg_s1 && !spd_fnd_q) begin
					spd_q <= ovr_rd_s1;
					spd_fnd_q <= 1'b1;
				end
			end else if (cmd.ax_next) begin
				for (int a = 0; a < AXIS_COUNT - 1; a++)
					acc_q[a] <= acc_q[a+1];
				acc_q[AXIS_COUNT-1] <= acc_q[0];
				ax_q <= ax_q + 1'b1;
			end
		end
	end

	assign mn_x = ACC_W'(min_q);
	assign mx_x = ACC_W'(max_q);
	assign neu_x = ACC_W'(neu_q);

	always_comb begin
		if (acc_q[0] > mx_x)
			cl = max_q;
		else if (acc_q[0] < mn_x)
			cl = min_q;
		else
			cl = acc_q[0][UNITS_W-1:0];
	end

	assign num_c = NUM_W'(cl) - NUM_W'(neu_q);
	assign dif = NUM_W'(max_q) - NUM_W'(min_q);
	assign den_c = (DEN_W'(dif) <<< 4) + (DEN_W'(dif) <<< 3) + DEN_W'(dif);

	assign nmag = p2_q[P2_W-1] ? MAG_W'(-p2_q) : MAG_W'(p2_q);
	assign dmag = den_q[DEN_W-1] ? DMAG_W'(-den_q) : DMAG_W'(den_q);

	always_ff @(posedge clk) begin
		if (cmd.ax_load) begin
			num_q <= num_c;
			den_q <= den_c;
		end
		if (cmd.mul1)
			p1_q <= num_q * $signed({1'b0, spd_q});
		if (cmd.mul2)
			p2_q <= p1_q * $signed({1'b0, per_q});
		if (cmd.div_start)
			sign_q <= p2_q[P2_W-1] ^ den_q[DEN_W-1];
	end

	vmea_div #(
		.NW(MAG_W),
		.DW(DMAG_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(nmag),
		.den(dmag),
		.done(div_done),
		.quo(quo)
	);

	assign neg = sign_q ^ (int'(ax_q) == VWHEEL_AXIS);

	always_comb begin
		if (!neg)
			pix_c = (quo > MAG_W'(32767)) ? 16'sh7FFF : $signed(quo[PIX_W-1:0]);
		else
			pix_c = (quo > MAG_W'(32768)) ? 16'sh8000 : $signed(-quo[PIX_W-1:0]);
	end

	always_comb begin
		push_v = 1'b0;
		push_kind = EV_MOVE;
		push_btn = '0;
		push_axis = '0;
		push_pix = '0;
		if (cmd.btn_step && chg_q[0]) begin
			push_v = 1'b1;
			push_kind = nxt_q[0] ? EV_DOWN : EV_UP;
			push_btn = BTN_W'(bcnt_q);
		end else if (cmd.ax_result && quo != '0) begin
			push_v = 1'b1;
			push_axis = AXIS_W'(ax_q);
			push_pix = pix_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			ev_stb_q <= 1'b0;
		end else begin
			ev_stb_q <= 1'b0;
			if (push_v) begin
				pend_v_q <= 1'b1;
				ev_stb_q <= pend_v_q;
			end else if (cmd.flush && pend_v_q) begin
				pend_v_q <= 1'b0;
				ev_stb_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_v) begin
			pend_kind_q <= push_kind;
			pend_btn_q <= push_btn;
			pend_axis_q <= push_axis;
			pend_pix_q <= push_pix;
		end
		if (push_v || cmd.flush) begin
			ev_kind_q <= pend_kind_q;
			ev_btn_q <= pend_btn_q;
			ev_axis_q <= pend_axis_q;
			ev_pix_q <= pend_pix_q;
			ev_last_q <= !push_v;
		end
	end

	assign result_strobe = ev_stb_q;
	assign event_kind = ev_kind_q;
	assign event_button = ev_btn_q;
	assign event_axis = ev_axis_q;
	assign pixels = ev_pix_q;
	assign last = ev_last_q;

	always_comb begin
		sts.mark = (func_q == FN_PRESS) || (func_q == FN_RELEASE);
		sts.move_ok = (func_q == FN_MOVE) && (int'(axis_q) < AXIS_COUNT);
		sts.ovr = func_q == FN_OVERRIDE;
		sts.tick = func_q == FN_TICK;
		sts.srch_done = vs_s1 && (last_s1 || hit);
		sts.btn_done = bcnt_q == BW'(BUTTON_COUNT - 1);
		sts.tick_move = focus_q && !term_q;
		sts.scan_done = vs_s1 && last_s1;
		sts.ax_skip = (acc_q[0] == neu_x) || (den_c == '0);
		sts.div_done = div_done;
		sts.ax_last = ax_q == AXW'(AXIS_COUNT - 1);
	end

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stb_q && ev_last_q |=> !ev_stb_q)
		else $error("event followed the final event of a tick");

	a_move_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stb_q && ev_kind_q == EV_MOVE |-> ev_pix_q != '0)
		else $error("movement event with zero pixels");

	a_button_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stb_q && ev_kind_q != EV_MOVE |-> ev_pix_q == '0 && ev_axis_q == '0)
		else $error("button event carries movement fields");

endmodule

@@ hdl/vmea_ctrl.sv @@
module vmea_ctrl import vmea_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DECODE = 13'b0000000000010,
		S_SRCH   = 13'b0000000000100,
		S_COMMIT = 13'b0000000001000,
		S_BTN    = 13'b0000000010000,
		S_SCAN   = 13'b0000000100000,
		S_CLAMP  = 13'b0000001000000,
		S_MUL1   = 13'b0000010000000,
		S_MUL2   = 13'b0000100000000,
		S_DIVGO  = 13'b0001000000000,
		S_DIV    = 13'b0010000000000,
		S_RES    = 13'b0100000000000,
		S_FLUSH  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.mark) begin
					cmd.mark = 1'b1;
					state_d = S_IDLE;
				end else if (sts.move_ok || sts.ovr) begin
					cmd.srch_start = 1'b1;
					state_d = S_SRCH;
				end else if (sts.tick) begin
					cmd.tick_init = 1'b1;
					state_d = S_BTN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SRCH: begin
				cmd.srch_run = 1'b1;
				if (sts.srch_done)
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			S_BTN: begin
				cmd.btn_step = 1'b1;
				if (sts.btn_done) begin
					if (sts.tick_move) begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done)
					state_d = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.ax_load = 1'b1;
				if (sts.ax_skip) begin
					cmd.ax_next = 1'b1;
					state_d = sts.ax_last ? S_FLUSH : S_CLAMP;
				end else begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done)
					state_d = S_RES;
			end
			S_RES: begin
				cmd.ax_result = 1'b1;
				cmd.ax_next = 1'b1;
				state_d = sts.ax_last ? S_FLUSH : S_CLAMP;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_start_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_DECODE)
		else $error("accepted transaction was not decoded");

endmodule

@@ hdl/virtual_mouse_event_aggregator.sv @@
// Movement and override items search the source identity memory one slot per cycle, stopping
// at a matching identity or at the last slot.
// A tick steps through the buttons, walks the contribution memory and runs the bit-serial divider
// for each moving axis.
// One item is in flight at a time; events appear one per strobe and cannot be held off.
// Reset clears all marks, buttons, source and override valid bits and loads register defaults.
module virtual_mouse_event_aggregator import vmea_pkg::*; #(
	parameter int SOURCE_SLOTS = 16,
	parameter int BUTTON_COUNT = 5,
	parameter int AXIS_COUNT = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [FUNC_W-1:0]         func,
	input  logic [BTN_W-1:0]          button,
	input  logic [AXIS_W-1:0]         axis,
	input  logic signed [UNITS_W-1:0] movement_units,
	input  logic [ID_W-1:0]           source_id,
	input  logic                      override_present,
	input  logic [SPD_W-1:0]          speed_percent,
	input  logic                      has_focus,
	input  logic                      terminate,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [UNITS_W-1:0]        cfg_data,
	output logic                      result_strobe,
	output logic [KIND_W-1:0]         event_kind,
	output logic [BTN_W-1:0]          event_button,
	output logic [AXIS_W-1:0]         event_axis,
	output logic signed [PIX_W-1:0]   pixels,
	output logic                      last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	vmea_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sts(sts),
		.cmd(cmd)
	);

	vmea_dp #(
		.SOURCE_SLOTS(SOURCE_SLOTS),
		.BUTTON_COUNT(BUTTON_COUNT),
		.AXIS_COUNT(AXIS_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.func(func),
		.button(button),
		.axis(axis),
		.movement_units(movement_units),
		.source_id(source_id),
		.override_present(override_present),
		.speed_percent(speed_percent),
		.has_focus(has_focus),
		.terminate(terminate),
		.cfg_wr(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.event_kind(event_kind),
		.event_button(event_button),
		.event_axis(event_axis),
		.pixels(pixels),
		.last(last)
	);

endmodule
